@@ sv/sbt_pkg.sv @@
`timescale 1ns / 1ps
// Shared definitions for the subsumption table: beat widths, default sizes
// and the command and status groups between controller and datapath.
// No dependencies.
package sbt_pkg;

  localparam int unsigned ENTRIES_DEF    = 16;
  localparam int unsigned VARS_DEF       = 64;
  localparam int unsigned MASK_W         = 64;
  localparam int unsigned IN_TDATA_W     = 2 * MASK_W;
  localparam int unsigned CNT_OUT_W      = 5;
  localparam int unsigned OUT_TDATA_W    = 16;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_TEST   = 1'b1;

  typedef struct packed {
    logic clear_wr;
    logic load;
    logic rd_en;
    logic commit;
  } sbt_cmd_t;

  typedef struct packed {
    logic addr_last;
  } sbt_sts_t;

endpackage

@@ sv/sbt_ctrl.sv @@
`timescale 1ns / 1ps
// Controller of the subsumption table: sequences the clearing pass, the
// entry scan and the commit, and owns both channel handshakes.
// Depends on sbt_pkg.
module sbt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output sbt_pkg::sbt_cmd_t cmd,
  input  sbt_pkg::sbt_sts_t sts
);
  import sbt_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   commit_ok;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign commit_ok  = (state_r == ST_COMMIT) && (!out_valid_r || out_tready);

  always_comb begin
    cmd          = '0;
    cmd.clear_wr = (state_r == ST_CLEAR);
    cmd.load     = (state_r == ST_IDLE) && in_tvalid;
    cmd.rd_en    = (state_r == ST_SCAN);
    cmd.commit   = commit_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      if (commit_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          if (sts.addr_last) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_tvalid) begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (sts.addr_last) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_r <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (commit_ok) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/sbt_dp.sv @@
`timescale 1ns / 1ps
// Datapath of the subsumption table: entry memory, scan address, one pair of
// subset comparators, scan flags, occupancy count and the result register.
// Depends on sbt_pkg.
module sbt_dp #(
  parameter int unsigned ENTRIES = sbt_pkg::ENTRIES_DEF,
  parameter int unsigned VARS    = sbt_pkg::VARS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sbt_pkg::sbt_cmd_t               cmd,
  output sbt_pkg::sbt_sts_t               sts,
  input  logic                            in_action,
  input  logic [sbt_pkg::MASK_W-1:0]      in_pos,
  input  logic [sbt_pkg::MASK_W-1:0]      in_neg,
  output logic [sbt_pkg::OUT_TDATA_W-1:0] res_data
);
  import sbt_pkg::*;

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned WW = 2 * VARS + 1;

  // Each word holds the valid flag on top, then the positive and negative masks.
  logic [WW-1:0]   mem [ENTRIES];
  logic [WW-1:0]   rd_r;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  logic [WW-1:0]   mem_wd;

  logic [AW-1:0]   addr_r;
  logic [AW-1:0]   cmp_idx_r;
  logic            cmp_v_r;
  logic            act_r;
  logic [VARS-1:0] qp_r;
  logic [VARS-1:0] qn_r;
  logic            hit_r;
  logic            sub_r;
  logic            slot_found_r;
  logic [AW-1:0]   slot_r;
  logic [CW-1:0]   removed_r;
  logic [CW-1:0]   occ_r;
  logic [OUT_TDATA_W-1:0] res_r;

  logic            e_valid;
  logic [VARS-1:0] e_pos;
  logic [VARS-1:0] e_neg;
  logic            q_in_e;
  logic            e_in_q;
  logic            do_remove;
  logic            do_store;
  logic            ovf;
  logic [CW-1:0]   occ_nxt;
  logic [CNT_OUT_W-1:0] removed_sat;
  logic [CNT_OUT_W-1:0] occ_sat;

  assign e_valid   = rd_r[WW-1];
  assign e_pos     = rd_r[2*VARS-1:VARS];
  assign e_neg     = rd_r[VARS-1:0];
  assign q_in_e    = ((qp_r & ~e_pos) == '0) && ((qn_r & ~e_neg) == '0);
  assign e_in_q    = ((e_pos & ~qp_r) == '0) && ((e_neg & ~qn_r) == '0);
  assign do_remove = cmp_v_r && (act_r == ACT_INSERT) && e_valid && q_in_e;
  assign do_store  = (act_r == ACT_INSERT) && !sub_r && slot_found_r;
  assign ovf       = (act_r == ACT_INSERT) && !sub_r && !slot_found_r;
  assign occ_nxt   = occ_r - removed_r + CW'(do_store);

  assign removed_sat = (32'(removed_r) > 32'd31) ? CNT_OUT_W'(31) : CNT_OUT_W'(removed_r);
  assign occ_sat     = (32'(occ_nxt) > 32'd31) ? CNT_OUT_W'(31) : CNT_OUT_W'(occ_nxt);

  assign sts.addr_last = (addr_r == AW'(ENTRIES - 1));
  assign res_data      = res_r;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_r;
    mem_wd = '0;
    priority if (cmd.clear_wr) begin
      mem_we = 1'b1;
    end else if (do_remove) begin
      mem_we = 1'b1;
      mem_wa = cmp_idx_r;
      mem_wd = {1'b0, rd_r[WW-2:0]};
    end else if (cmd.commit && do_store) begin
      mem_we = 1'b1;
      mem_wa = slot_r;
      mem_wd = {1'b1, qp_r, qn_r};
    end else begin
      mem_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.rd_en) begin
      rd_r <= mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r  <= '0;
      cmp_v_r <= 1'b0;
      occ_r   <= '0;
    end else begin
      cmp_v_r <= cmd.rd_en;
      if (cmd.load) begin
        addr_r <= '0;
      end else if (cmd.clear_wr || cmd.rd_en) begin
        addr_r <= sts.addr_last ? '0 : addr_r + AW'(1);
      end
      if (cmd.commit) begin
        occ_r <= occ_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= addr_r;
    if (cmd.load) begin
      act_r        <= in_action;
      qp_r         <= in_pos[VARS-1:0];
      qn_r         <= in_neg[VARS-1:0];
      hit_r        <= 1'b0;
      sub_r        <= 1'b0;
      slot_found_r <= 1'b0;
      slot_r       <= '0;
      removed_r    <= '0;
    end else if (cmp_v_r) begin
      if (act_r == ACT_TEST) begin
        if (e_valid && e_in_q) begin
          hit_r <= 1'b1;
        end
      end else begin
        if (do_remove) begin
          removed_r <= removed_r + CW'(1);
        end else if (e_valid && e_in_q) begin
          sub_r <= 1'b1;
        end
        if ((!e_valid || do_remove) && !slot_found_r) begin
          slot_found_r <= 1'b1;
          slot_r       <= cmp_idx_r;
        end
      end
    end
    if (cmd.commit) begin
      res_r <= {2'b00, occ_sat, removed_sat, ovf,
                (act_r == ACT_INSERT) && sub_r, do_store,
                (act_r == ACT_TEST) && hit_r};
    end
  end

endmodule

@@ sv/subsumption_table_core.sv @@
`timescale 1ns / 1ps
// Top level of the subsumption table: joins the controller and the datapath.
// Depends on sbt_pkg, sbt_ctrl and sbt_dp.
//
//   Channel | Direction | Carries
//   in_     | slave     | tuser: action; tdata: pos_mask, neg_mask
//   out_    | master    | tdata: hit, stored, subsumed, overflow, removed_count, occupancy
//
// After reset a clearing pass marks every entry free; no beat is taken
// meanwhile. Each accepted item is then scanned with one entry memory read per
// cycle through a single pair of subset comparators before its result is
// formed. A result waits in the output register while the next beat is taken;
// the commit of that next item holds until the result has gone.
module subsumption_table_core #(
  parameter int unsigned ENTRIES = sbt_pkg::ENTRIES_DEF,
  parameter int unsigned VARS    = sbt_pkg::VARS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sbt_pkg::IN_TDATA_W-1:0]  in_tdata,   // pos_mask, neg_mask
  input  logic                            in_tuser,   // action
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sbt_pkg::OUT_TDATA_W-1:0] out_tdata   // hit, stored, subsumed, overflow,
                                                      // removed_count, occupancy
);
  import sbt_pkg::*;

  sbt_cmd_t cmd;
  sbt_sts_t sts;

  sbt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  sbt_dp #(
    .ENTRIES (ENTRIES),
    .VARS    (VARS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_action (in_tuser),
    .in_pos    (in_tdata[MASK_W-1:0]),
    .in_neg    (in_tdata[IN_TDATA_W-1:MASK_W]),
    .res_data  (out_tdata)
  );

endmodule

@@ dv/sbt_table_monitor.sv @@
`timescale 1ns / 1ps
// Monitor for the subsumption table core: tracks its own copy of the literal-set table,
// predicts the outcome of every accepted beat and compares it with the result beats.
// Depends on sbt_pkg.
module sbt_table_monitor #(
  parameter int unsigned ENTRIES = sbt_pkg::ENTRIES_DEF,
  parameter int unsigned VARS    = sbt_pkg::VARS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [sbt_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [sbt_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                              fail_count,
  output int                              pending,
  output int                              results_seen,
  output int                              stored_seen,
  output int                              absorbed_seen,
  output int                              overflow_seen,
  output int                              hits_seen
);
  import sbt_pkg::*;

  localparam logic [MASK_W-1:0] LIT_MASK =
    (VARS >= MASK_W) ? {MASK_W{1'b1}} : ((64'd1 << VARS) - 64'd1);

  typedef struct packed {
    logic                 hit;
    logic                 stored;
    logic                 subsumed;
    logic                 overflow;
    logic [CNT_OUT_W-1:0] removed;
    logic [CNT_OUT_W-1:0] occupancy;
  } table_outcome_t;

  logic              slot_valid [ENTRIES];
  logic [MASK_W-1:0] slot_pos   [ENTRIES];
  logic [MASK_W-1:0] slot_neg   [ENTRIES];
  table_outcome_t    table_outcomes [$];

  function automatic logic subset_of(logic [MASK_W-1:0] sp, logic [MASK_W-1:0] sn,
                                     logic [MASK_W-1:0] bp, logic [MASK_W-1:0] bn);
    return ((sp & ~bp) == '0) && ((sn & ~bn) == '0);
  endfunction

  function automatic logic [CNT_OUT_W-1:0] clip_count(int unsigned n);
    return (n > 31) ? CNT_OUT_W'(31) : CNT_OUT_W'(n);
  endfunction

  function automatic table_outcome_t table_update(logic act, logic [MASK_W-1:0] qp_in,
                                                  logic [MASK_W-1:0] qn_in);
    table_outcome_t    r;
    logic [MASK_W-1:0] qp;
    logic [MASK_W-1:0] qn;
    logic              absorbed;
    int                free_slot;
    int unsigned       dropped;
    int unsigned       live;
    r         = '0;
    qp        = qp_in & LIT_MASK;
    qn        = qn_in & LIT_MASK;
    absorbed  = 1'b0;
    free_slot = -1;
    dropped   = 0;
    live      = 0;
    if (act == ACT_TEST) begin
      for (int i = 0; i < ENTRIES; i++)
        if (slot_valid[i] && subset_of(slot_pos[i], slot_neg[i], qp, qn)) r.hit = 1'b1;
    end else begin
      // Supersets go first, so the subset search only sees what is left.
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_valid[i] && subset_of(qp, qn, slot_pos[i], slot_neg[i])) begin
          slot_valid[i] = 1'b0;
          dropped++;
        end
      end
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_valid[i]) begin
          if (subset_of(slot_pos[i], slot_neg[i], qp, qn)) absorbed = 1'b1;
        end else if (free_slot < 0) begin
          free_slot = i;
        end
      end
      if (absorbed) begin
        r.subsumed = 1'b1;
      end else if (free_slot < 0) begin
        r.overflow = 1'b1;
      end else begin
        slot_valid[free_slot] = 1'b1;
        slot_pos[free_slot]   = qp;
        slot_neg[free_slot]   = qn;
        r.stored              = 1'b1;
      end
      r.removed = clip_count(dropped);
    end
    for (int i = 0; i < ENTRIES; i++)
      if (slot_valid[i]) live++;
    r.occupancy = clip_count(live);
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    table_outcome_t want;
    table_outcome_t got;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) slot_valid[i] = 1'b0;
      table_outcomes.delete();
      fail_count    = 0;
      results_seen  = 0;
      stored_seen   = 0;
      absorbed_seen = 0;
      overflow_seen = 0;
      hits_seen     = 0;
    end else begin
      if (in_tvalid && in_tready)
        table_outcomes.insert(table_outcomes.size(),
                              table_update(in_tuser, in_tdata[MASK_W-1:0],
                                           in_tdata[2*MASK_W-1:MASK_W]));
      if (out_tvalid && out_tready) begin
        got.hit       = out_tdata[0];
        got.stored    = out_tdata[1];
        got.subsumed  = out_tdata[2];
        got.overflow  = out_tdata[3];
        got.removed   = out_tdata[4 +: CNT_OUT_W];
        got.occupancy = out_tdata[4 + CNT_OUT_W +: CNT_OUT_W];
        if (table_outcomes.size() == 0) begin
          $error("result beat with no outstanding item: tdata 0x%0h", out_tdata);
          fail_count++;
        end else begin
          want = table_outcomes.pop_front();
          check_field("hit", want.hit, got.hit);
          check_field("stored", want.stored, got.stored);
          check_field("subsumed", want.subsumed, got.subsumed);
          check_field("overflow", want.overflow, got.overflow);
          check_field("removed_count", want.removed, got.removed);
          check_field("occupancy", want.occupancy, got.occupancy);
          results_seen++;
          stored_seen   += want.stored;
          absorbed_seen += want.subsumed;
          overflow_seen += want.overflow;
          hits_seen     += want.hit;
        end
      end
    end
    pending <= table_outcomes.size();
  end

endmodule

@@ dv/tb_subsumption_table_core.sv @@
`timescale 1ns / 1ps
// Testbench top for the subsumption table core: clock, reset, beat stimulus with
// random back-pressure and the final verdict. Depends on sbt_pkg,
// subsumption_table_core and sbt_table_monitor.
module tb_subsumption_table_core;
  import sbt_pkg::*;

  localparam int unsigned ENTRIES      = ENTRIES_DEF;
  localparam int          RANDOM_ITEMS = 1450;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          LONG_HOLD    = 300;

  typedef struct packed {
    logic [MASK_W-1:0] pos;
    logic [MASK_W-1:0] neg;
  } lit_set_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tuser   = ACT_INSERT;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int       fail_count;
  int       pending;
  int       results_seen;
  int       stored_seen;
  int       absorbed_seen;
  int       overflow_seen;
  int       hits_seen;
  int       cycle_count = 0;
  int       tx_idle_pct = 16;
  int       rx_idle_pct = 72;
  logic     long_hold   = 1'b0;
  lit_set_t recent_inserts [$];

  subsumption_table_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  sbt_table_monitor #(.ENTRIES(ENTRIES), .VARS(VARS_DEF)) monitor (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen),
    .stored_seen  (stored_seen),
    .absorbed_seen(absorbed_seen),
    .overflow_seen(overflow_seen),
    .hits_seen    (hits_seen)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_item(input logic act, input logic [MASK_W-1:0] p,
                           input logic [MASK_W-1:0] n);
    lit_set_t hist;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {n, p};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (act == ACT_INSERT) begin
      hist.pos = p;
      hist.neg = n;
      recent_inserts.insert(recent_inserts.size(), hist);
      if (recent_inserts.size() > ENTRIES) void'(recent_inserts.pop_front());
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Sparse sets share one of eight windows of variables, so that subsets, supersets
  // and a full table all turn up often.
  task automatic make_sparse(output logic [MASK_W-1:0] p, output logic [MASK_W-1:0] n);
    int unsigned base;
    int unsigned v;
    p    = '0;
    n    = '0;
    base = 8 * $urandom_range(7);
    repeat ($urandom_range(1, 3)) begin
      v = base + $urandom_range(7);
      if ($urandom_range(1)) p[v] = 1'b1;
      else n[v] = 1'b1;
    end
  endtask

  task automatic send_random_item();
    logic              act;
    logic [MASK_W-1:0] p;
    logic [MASK_W-1:0] n;
    int unsigned       r;
    lit_set_t          h;
    r   = $urandom_range(99);
    act = ($urandom_range(99) < 35) ? ACT_TEST : ACT_INSERT;
    if (r < 55) begin
      make_sparse(p, n);
    end else if (r < 80 && recent_inserts.size() > 0) begin
      h = recent_inserts[$urandom_range(recent_inserts.size() - 1)];
      p = h.pos;
      n = h.neg;
      if ($urandom_range(1)) begin
        if ($urandom_range(1)) p[$urandom_range(63)] = 1'b1;
        else n[$urandom_range(63)] = 1'b1;
      end else if (p != '0) begin
        p = p & (p - 1);
      end else begin
        n = n & (n - 1);
      end
    end else if (r < 90) begin
      p = {$urandom, $urandom};
      n = {$urandom, $urandom};
    end else begin
      make_sparse(p, n);
      p = ~p;
      n = ~n;
    end
    // The empty set would pin the table for good, so it is left to the closing beats.
    if (act == ACT_INSERT && p == '0 && n == '0) p[$urandom_range(63)] = 1'b1;
    send_item(act, p, n);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_item(ACT_TEST, '1, '1);
    send_item(ACT_INSERT, '1, '1);
    send_item(ACT_INSERT, '1, '1);
    send_item(ACT_INSERT, 64'd1 << 63, '0);
    for (int i = 0; i < ENTRIES - 1; i++) send_item(ACT_INSERT, 64'd1 << i, '0);
    send_item(ACT_INSERT, '0, 64'd1);
    send_item(ACT_INSERT, 64'h3, '0);
    send_item(ACT_TEST, 64'd1 << 5, '1);
    send_item(ACT_TEST, '0, '1);

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 72 : 0;
      rx_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 16 : 0;
      if (phase == 2) begin
        long_hold = 1'b1;
        repeat (12) send_random_item();
        drain_results();
      end
      for (int k = 0; k < RANDOM_ITEMS / 3; k++) send_random_item();
    end

    send_item(ACT_INSERT, '0, '0);
    send_item(ACT_TEST, '0, '0);
    send_item(ACT_INSERT, {$urandom, $urandom}, {$urandom, $urandom});

    drain_results();
    repeat (ENTRIES + 8) @(posedge clk);

    $display("Checked %0d result beats over inserts and tests under varying back-pressure.",
             results_seen);
    $display("Outcomes: %0d stored, %0d absorbed by a subset, %0d overflows, %0d test hits.",
             stored_seen, absorbed_seen, overflow_seen, hits_seen);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
